>>> hdl/rnf_pkg.sv
// Shared constants, types and helper functions for the radix number formatter.
`default_nettype none

package rnf_pkg;

	// Field and storage sizes
	localparam int INT_BITS        = 48;
	localparam int FRAC_BITS       = 24;
	localparam int MAX_FRAC_PLACES = 6;
	localparam int DIGIT_W         = 4;
	localparam int CHAR_W          = 7;
	localparam int RADIX_W         = 2;
	localparam int PLACES_W        = 3;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	// Base 2 needs one slot per magnitude bit, larger bases need fewer
	localparam int INT_DIGITS = INT_BITS;
	localparam int SLOT_W     = $clog2(INT_DIGITS);
	localparam int PLC_W      = $clog2(MAX_FRAC_PLACES + 1);
	localparam int FIDX_W     = $clog2(MAX_FRAC_PLACES);
	localparam int PROD_W     = FRAC_BITS + DIGIT_W;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h41;
	localparam logic [CHAR_W-1:0] CH_HEX_F = 7'h46;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;

	typedef enum logic [RADIX_W-1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	// Register word index (byte address bit 2)
	typedef enum logic {
		REG_RADIX  = 1'b0,
		REG_PLACES = 1'b1
	} reg_idx_t;

	localparam radix_t               RADIX_RESET  = RADIX_DEC;
	localparam logic [PLACES_W-1:0] PLACES_RESET = 3'd6;

	// Commands to the integer digit converter
	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} int_ctrl_t;

	// Commands to the fraction digit generator
	typedef struct packed {
		logic load;
		logic shift;
	} frac_ctrl_t;

	// Status from the fraction digit generator
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [PLC_W-1:0]   kept;
	} frac_stat_t;

	// Numeric base of a radix code
	function automatic logic [DIGIT_W:0] base_of(input radix_t r);
		logic [DIGIT_W:0] b;
		case (r)
			RADIX_BIN: b = 5'd2;
			RADIX_OCT: b = 5'd8;
			RADIX_DEC: b = 5'd10;
			default:   b = 5'd16;
		endcase
		return b;
	endfunction

	// ASCII glyph of one digit, upper case letters
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < DIGIT_W'(10)) begin
			return CH_ZERO + dx;
		end
		return CH_ALPHA + dx - CHAR_W'(10);
	endfunction

endpackage

`default_nettype wire

>>> hdl/rnf_int_conv.sv
// Bit-serial binary to base-N digit converter with a digit shift-out path.
`default_nettype none

module rnf_int_conv (
	input  wire logic                          clk,
	input  wire rnf_pkg::int_ctrl_t            ctrl,
	input  wire rnf_pkg::radix_t               radix,
	input  wire logic [rnf_pkg::INT_BITS-1:0] mag_in,
	output logic [rnf_pkg::DIGIT_W-1:0]        top_digit
);
	import rnf_pkg::*;

	logic [INT_BITS-1:0]                 mag_q;
	logic [INT_DIGITS-1:0][DIGIT_W-1:0]  digits_q;
	logic [INT_DIGITS-1:0][DIGIT_W-1:0]  digits_nxt;
	logic [INT_DIGITS-1:0]               carry_in;
	logic [INT_DIGITS-1:0]               over;
	logic [INT_DIGITS-1:0][DIGIT_W:0]    twice;
	logic [DIGIT_W:0]                    base;
	logic [DIGIT_W-1:0]                  half;

	assign base = base_of(radix);
	assign half = base[DIGIT_W:1];

	// Double every digit and add the bit shifted in; a digit at or above half the
	// base wraps and carries into the next slot, so no carry ripples through the slots
	always_comb begin
		for (int i = 0; i < INT_DIGITS; i++) begin
			over[i] = digits_q[i] >= half;
		end
		carry_in[0] = mag_q[INT_BITS-1];
		for (int i = 1; i < INT_DIGITS; i++) begin
			carry_in[i] = over[i-1];
		end
		for (int i = 0; i < INT_DIGITS; i++) begin
			twice[i] = {digits_q[i], carry_in[i]};
			if (over[i]) begin
				digits_nxt[i] = DIGIT_W'(twice[i] - base);
			end else begin
				digits_nxt[i] = twice[i][DIGIT_W-1:0];
			end
		end
	end

	// Load, convert one bit per cycle, or shift digits out most significant first
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q    <= mag_in;
			digits_q <= '0;
		end else if (ctrl.step) begin
			mag_q    <= {mag_q[INT_BITS-2:0], 1'b0};
			digits_q <= digits_nxt;
		end else if (ctrl.shift) begin
			digits_q <= {digits_q[INT_DIGITS-2:0], {DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = digits_q[INT_DIGITS-1];

endmodule

`default_nettype wire

>>> hdl/rnf_frac_gen.sv
// Fraction digit generator: one multiply-by-base step per cycle, with trim count.
`default_nettype none

module rnf_frac_gen (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rnf_pkg::frac_ctrl_t             ctrl,
	input  wire rnf_pkg::radix_t                 radix,
	input  wire logic [rnf_pkg::PLACES_W-1:0]    places,
	input  wire logic [rnf_pkg::FRAC_BITS-1:0]   frac_in,
	output rnf_pkg::frac_stat_t                  stat
);
	import rnf_pkg::*;

	logic [FRAC_BITS-1:0]                     frac_q;
	logic [MAX_FRAC_PLACES-1:0][DIGIT_W-1:0]  fdig_q;
	logic [PLC_W-1:0]                         cnt_q;
	logic [PLC_W-1:0]                         kept_q;
	logic [PLC_W-1:0]                         limit;
	logic [PROD_W-1:0]                        prod;
	logic [DIGIT_W-1:0]                       digit;
	logic                                     run;

	// Saturate the place count
	always_comb begin
		if (places > PLACES_W'(MAX_FRAC_PLACES)) begin
			limit = PLC_W'(MAX_FRAC_PLACES);
		end else begin
			limit = PLC_W'(places);
		end
	end

	// Multiply by the base with shifts and at most one add
	always_comb begin
		case (radix)
			RADIX_BIN: prod = PROD_W'({frac_q, 1'b0});
			RADIX_OCT: prod = PROD_W'({frac_q, 3'b000});
			RADIX_DEC: prod = PROD_W'({frac_q, 3'b000}) + PROD_W'({frac_q, 1'b0});
			default:   prod = {frac_q, 4'b0000};
		endcase
	end

	assign digit = prod[PROD_W-1:FRAC_BITS];
	assign run   = cnt_q < limit;

	// Count produced digits and remember the position of the last nonzero one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			kept_q <= '0;
		end else if (ctrl.load) begin
			cnt_q  <= '0;
			kept_q <= '0;
		end else if (run) begin
			cnt_q <= cnt_q + PLC_W'(1);
			if (digit != '0) begin
				kept_q <= cnt_q + PLC_W'(1);
			end
		end
	end

	// Hold the fraction and the digit line; shift digits out toward slot zero
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			frac_q <= frac_in;
		end else if (run) begin
			frac_q                    <= prod[FRAC_BITS-1:0];
			fdig_q[cnt_q[FIDX_W-1:0]] <= digit;
		end else if (ctrl.shift) begin
			for (int i = 0; i < MAX_FRAC_PLACES - 1; i++) begin
				fdig_q[i] <= fdig_q[i+1];
			end
			fdig_q[MAX_FRAC_PLACES-1] <= '0;
		end
	end

	assign stat.digit = fdig_q[0];
	assign stat.kept  = kept_q;

endmodule

`default_nettype wire

>>> hdl/rnf_seq.sv
// Sequencer: runs the conversion, then emits sign, digits, point and fraction.
`default_nettype none

module rnf_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        sign_in,
	input  wire logic [rnf_pkg::DIGIT_W-1:0] top_digit,
	input  wire rnf_pkg::frac_stat_t         fstat,
	output logic                             busy,
	output rnf_pkg::int_ctrl_t               int_ctrl,
	output rnf_pkg::frac_ctrl_t              frac_ctrl,
	output logic [rnf_pkg::CHAR_W-1:0]       char_code,
	output logic                             strobe,
	output logic                             last
);
	import rnf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_INT,
		ST_DOT,
		ST_FRAC
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  cnt_q;
	logic [PLC_W-1:0]   fcnt_q;
	logic               lead_q;
	logic               sign_q;
	logic [CHAR_W-1:0]  char_code_q;
	logic               strobe_q;
	logic               last_q;
	logic               accept;
	logic               final_slot;
	logic               show;
	logic               no_frac;

	assign accept     = (state_q == ST_IDLE) && start;
	assign final_slot = cnt_q == '0;
	assign show       = (top_digit != '0) || !lead_q || final_slot;
	assign no_frac    = fstat.kept == '0;

	// Drive the datapath units
	assign int_ctrl.load   = accept;
	assign int_ctrl.step   = state_q == ST_CONV;
	assign int_ctrl.shift  = state_q == ST_INT;
	assign frac_ctrl.load  = accept;
	assign frac_ctrl.shift = state_q == ST_FRAC;

	// State and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fcnt_q      <= '0;
			lead_q      <= 1'b1;
			sign_q      <= 1'b0;
			char_code_q <= '0;
			strobe_q    <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						sign_q  <= sign_in;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == SLOT_W'(INT_BITS - 1)) begin
						cnt_q   <= SLOT_W'(INT_DIGITS - 1);
						lead_q  <= 1'b1;
						state_q <= sign_q ? ST_SIGN : ST_INT;
					end else begin
						cnt_q <= cnt_q + SLOT_W'(1);
					end
				end
				ST_SIGN: begin
					char_code_q <= CH_MINUS;
					strobe_q    <= 1'b1;
					state_q     <= ST_INT;
				end
				ST_INT: begin
					// Drop leading zeros but keep the units digit
					if (show) begin
						char_code_q <= glyph(top_digit);
						strobe_q    <= 1'b1;
						lead_q      <= 1'b0;
						last_q      <= final_slot && no_frac;
					end
					if (final_slot) begin
						state_q <= no_frac ? ST_IDLE : ST_DOT;
					end else begin
						cnt_q <= cnt_q - SLOT_W'(1);
					end
				end
				ST_DOT: begin
					char_code_q <= CH_DOT;
					strobe_q    <= 1'b1;
					fcnt_q      <= '0;
					state_q     <= ST_FRAC;
				end
				ST_FRAC: begin
					char_code_q <= glyph(fstat.digit);
					strobe_q    <= 1'b1;
					if (fcnt_q == fstat.kept - PLC_W'(1)) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						fcnt_q <= fcnt_q + PLC_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign char_code = char_code_q;
	assign strobe    = strobe_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> hdl/radix_number_formatter.sv
// Top level of the radix number formatter: register port, converter and sequencer.
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+----------------------------------
//  input    | start, busy (transfer: start&!busy)| negative, int_magnitude, frac_bits
//  result   | strobe (one cycle, no backpressure)| char_code, last
//  config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// A number keeps busy high from its transfer through bit-serial base conversion of
// the magnitude, then a 48-slot scan of the digit shift register (leading zeros
// skipped), plus sign, point and up to 6 fraction digits. The final character
// shows in the same cycle as busy drops.
// Fraction digits are made in the first cycles of the conversion.
// Reset (arst_n low) clears the sequencer and restores base 10 with 6 places.
// The receiver cannot stall: each character is shown for exactly one cycle.
`default_nettype none

module radix_number_formatter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           negative,
	input  wire logic [rnf_pkg::INT_BITS-1:0]  int_magnitude,
	input  wire logic [rnf_pkg::FRAC_BITS-1:0] frac_bits,
	output logic [rnf_pkg::CHAR_W-1:0]          char_code,
	output logic                                last,
	output logic                                strobe,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rnf_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rnf_pkg::DATA_W-1:0]    pwdata,
	output logic [rnf_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);
	import rnf_pkg::*;

	radix_t               radix_q;
	logic [PLACES_W-1:0]  places_q;
	reg_idx_t             reg_sel;
	logic                 sign_in;
	int_ctrl_t            int_ctrl;
	frac_ctrl_t           frac_ctrl;
	frac_stat_t           fstat;
	logic [DIGIT_W-1:0]   top_digit;

	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1]);
	assign pready  = 1'b1;

	// Register writes on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			places_q <= PLACES_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_RADIX:  radix_q  <= radix_t'(pwdata[RADIX_W-1:0]);
				REG_PLACES: places_q <= pwdata[PLACES_W-1:0];
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (reg_sel)
			REG_RADIX:  prdata = DATA_W'(radix_q);
			REG_PLACES: prdata = DATA_W'(places_q);
		endcase
	end

	// Negative zero gets no sign
	assign sign_in = negative && ((|int_magnitude) || (|frac_bits));

	rnf_int_conv u_int_conv (
		.clk       (clk),
		.ctrl      (int_ctrl),
		.radix     (radix_q),
		.mag_in    (int_magnitude),
		.top_digit (top_digit)
	);

	rnf_frac_gen u_frac_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (frac_ctrl),
		.radix   (radix_q),
		.places  (places_q),
		.frac_in (frac_bits),
		.stat    (fstat)
	);

	rnf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sign_in   (sign_in),
		.top_digit (top_digit),
		.fstat     (fstat),
		.busy      (busy),
		.int_ctrl  (int_ctrl),
		.frac_ctrl (frac_ctrl),
		.char_code (char_code),
		.strobe    (strobe),
		.last      (last)
	);

endmodule

`default_nettype wire

>>> hdl/rnf_checker.sv
// Port-level checks for the radix number formatter and their binding.
`default_nettype none

module rnf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic [rnf_pkg::CHAR_W-1:0] char_code,
	input wire logic                        last,
	input wire logic                        strobe
);
	import rnf_pkg::*;

	// An accepted transfer makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after input transfer");

	// Characters before the final one arrive while the number is still in work
	a_busy_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("character without last shown while idle");

	// The final character is never directly followed by another
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("character right after the final character");

	// Only digits, upper case hex letters, minus and point are emitted
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((char_code >= CH_ZERO && char_code <= CH_NINE) ||
			(char_code >= CH_ALPHA && char_code <= CH_HEX_F) ||
			char_code == CH_MINUS || char_code == CH_DOT))
		else $error("character outside the output set");

endmodule

bind radix_number_formatter rnf_checker u_rnf_checker (.*);

`default_nettype wire
